[rtl/bfb_pkg.sv]
// Shared types and constants for the bloom filter builder.
// Has no dependencies. Every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package bfb_pkg;

    // Input word action codes.
    localparam logic [1:0] ACT_BYTE   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_NUM_HASHES  = 1'b0;
    localparam logic CFG_FILTER_BITS = 1'b1;

    // Hash constants.
    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3; // prime is 2^40 + 0x1b3
    localparam logic [63:0] MIX_GOLD = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2   = 64'h94D049BB133111EB;

    localparam int HASH_W = 64;
    localparam int POS_W  = 17;  // bit positions stay below the saturated filter size
    localparam int IDX_W  = 10;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        logic [1:0]        action;
        logic [HASH_W-1:0] hash;
        logic [IDX_W-1:0]  word_index;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/bfb_front.sv]
// Front end: accepts input words, keeps the running FNV-1a-style hash and
// forwards insert, read and clear commands. Depends on bfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfb_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 enable,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_action,
    input  wire  [7:0]          s_data_byte,
    input  wire  [9:0]          s_word_index,
    output logic                push,
    output bfb_pkg::cmd_t       push_cmd,
    input  wire                 queue_full
);

    logic [63:0] hash_reg, hash_next;
    logic [63:0] x;
    logic        accept;

    // Bytes never touch the queue, so they go through even when it is full.
    assign s_ready = enable && ((s_action == bfb_pkg::ACT_BYTE) || !queue_full);
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_action != bfb_pkg::ACT_BYTE);

    assign push_cmd.action     = s_action;
    assign push_cmd.hash       = hash_reg;
    assign push_cmd.word_index = s_word_index;

    // Multiplying by the FNV prime is a 40-bit shift plus a 9-bit product.
    assign x = hash_reg ^ {56'd0, s_data_byte};

    always_comb begin
        hash_next = hash_reg;
        if (accept) begin
            case (s_action)
                bfb_pkg::ACT_BYTE: begin
                    hash_next = {x[23:0], 40'd0} + (x * {55'd0, bfb_pkg::FNV_PRIME_LOW});
                end
                bfb_pkg::ACT_INSERT: begin
                    hash_next = bfb_pkg::FNV_BASIS;
                end
                default: begin
                    hash_next = hash_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= bfb_pkg::FNV_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfb_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on bfb_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module bfb_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  bfb_pkg::cmd_t   push_cmd,
    output logic            full,
    input  wire             pop,
    output bfb_pkg::cmd_t   head,
    output logic            empty
);

    localparam int DEPTH = 4;

    bfb_pkg::cmd_t slot_reg [DEPTH];
    logic [1:0]    wr_ptr_reg, wr_ptr_next;
    logic [1:0]    rd_ptr_reg, rd_ptr_next;
    logic [2:0]    count_reg, count_next;

    assign full  = (count_reg == 3'(DEPTH));
    assign empty = (count_reg == 3'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfb_mix.sv]
// Multicycle splitmix64 finalizer built on one shared 32x32 multiplier.
// Depends on bfb_pkg for the mixing constants.
`timescale 1ns / 1ps
`default_nettype none
module bfb_mix (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] din,
    output logic        done,
    output logic [63:0] dout
);

    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] res_reg, res_next;
    logic [1:0]  step_reg, step_next;
    logic        pass_reg, pass_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] coef;
    logic [31:0] op_a, op_b;
    logic [63:0] seed;
    logic [63:0] fin;

    assign done = done_reg;
    assign dout = res_reg;
    assign coef = pass_reg ? bfb_pkg::MIX_C2 : bfb_pkg::MIX_C1;
    assign seed = din + bfb_pkg::MIX_GOLD;
    assign fin  = acc_reg + {prod_reg[31:0], 32'd0};

    // The low 64 bits of a 64x64 product take three 32x32 partial products.
    always_comb begin
        case (step_reg)
            2'd0: begin
                op_a = a_reg[31:0];
                op_b = coef[31:0];
            end
            2'd1: begin
                op_a = a_reg[31:0];
                op_b = coef[63:32];
            end
            default: begin
                op_a = a_reg[63:32];
                op_b = coef[31:0];
            end
        endcase
    end

    always_comb begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        prod_next = {32'd0, op_a} * {32'd0, op_b};
        res_next  = res_reg;
        step_next = step_reg;
        pass_next = pass_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = seed ^ (seed >> 30);
            step_next = 2'd0;
            pass_next = 1'b0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd1: begin
                    acc_next = prod_reg;
                end
                2'd2: begin
                    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                end
                2'd3: begin
                    if (!pass_reg) begin
                        a_next    = fin ^ (fin >> 27);
                        pass_next = 1'b1;
                    end else begin
                        res_next  = fin ^ (fin >> 31);
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        step_reg <= step_next;
        pass_reg <= pass_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfb_mod.sv]
// Multicycle reduction of a 64-bit value modulo a 17-bit modulus,
// four restoring steps per cycle. Depends on bfb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module bfb_mod (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [63:0]                  din,
    input  wire  [bfb_pkg::POS_W-1:0]    modulus,
    output logic                         done,
    output logic [bfb_pkg::POS_W-1:0]    rem
);

    localparam int PW = bfb_pkg::POS_W;

    logic [63:0]   val_reg, val_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW:0]   trial;
    logic [PW-1:0] r;

    assign done = done_reg;
    assign rem  = rem_reg;

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r         = rem_reg;
        trial     = '0;
        if (start) begin
            val_next  = din;
            rem_next  = '0;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int i = 0; i < 4; i++) begin
                trial = {r, val_reg[63-i]};
                if (trial >= {1'b0, modulus}) begin
                    trial = trial - {1'b0, modulus};
                end
                r = trial[PW-1:0];
            end
            rem_next = r;
            val_next = {val_reg[59:0], 4'd0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfb_back.sv]
// Back end: command sequencer, filter memory and output register.
// Depends on bfb_pkg, bfb_mix and bfb_mod.
`timescale 1ns / 1ps
`default_nettype none
module bfb_back #(
    parameter int FILTER_WORDS = 1024
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire  [4:0]                  num_hashes,
    input  wire  [16:0]                 filter_bits,
    input  bfb_pkg::cmd_t               head,
    input  wire                         empty,
    output logic                        pop,
    output logic                        ready_init,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [63:0]                 m_read_word
);

    localparam int AW  = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
    localparam int CAP = 64 * FILTER_WORDS;
    localparam int PW  = bfb_pkg::POS_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_MIX   = 4'd2;
    localparam logic [3:0] ST_MOD   = 4'd3;
    localparam logic [3:0] ST_SET   = 4'd4;
    localparam logic [3:0] ST_RDREQ = 4'd5;
    localparam logic [3:0] ST_RDOUT = 4'd6;

    logic [63:0] mem [FILTER_WORDS];
    logic [63:0] rdata_reg;

    logic [3:0]    state_reg, state_next;
    logic          init_reg, init_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [63:0]   h1_reg, h1_next;
    logic [63:0]   h2_reg, h2_next;
    logic [63:0]   acc_reg, acc_next;
    logic [4:0]    t_reg, t_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [5:0]    bit_reg, bit_next;
    logic          oor_reg, oor_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_data_reg, out_data_next;

    logic          mem_re, mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    logic          mix_start, mix_done;
    logic [63:0]   mix_out;
    logic          mod_start, mod_done;
    logic [63:0]   mod_in;
    logic [PW-1:0] mod_rem;
    logic [PW-1:0] eff_m;
    logic [4:0]    eff_k;
    logic [31:0]   idx_wide;
    logic [31:0]   word_wide;

    assign pop         = (state_reg == ST_IDLE) && !empty;
    assign ready_init  = init_reg;
    assign m_valid     = out_valid_reg;
    assign m_read_word = out_data_reg;
    assign idx_wide    = {22'd0, head.word_index};
    assign word_wide   = {21'd0, mod_rem[PW-1:6]};

    // Saturate the configuration to its legal ranges.
    always_comb begin
        if (num_hashes == 5'd0) begin
            eff_k = 5'd1;
        end else if (num_hashes > 5'd16) begin
            eff_k = 5'd16;
        end else begin
            eff_k = num_hashes;
        end
        if (filter_bits < 17'd8) begin
            eff_m = 17'd8;
        end else if ({15'd0, filter_bits} > CAP) begin
            eff_m = PW'(CAP);
        end else begin
            eff_m = filter_bits;
        end
    end

    bfb_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .din     (h1_reg),
        .done    (mix_done),
        .dout    (mix_out)
    );

    bfb_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .din     (mod_in),
        .modulus (eff_m),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_addr_next  = clr_addr_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        acc_next       = acc_reg;
        t_next         = t_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = rdata_reg | (64'd1 << bit_reg);
        mix_start      = 1'b0;
        mod_start      = 1'b0;
        mod_in         = acc_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 64'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(FILTER_WORDS - 1)) begin
                    clr_addr_next = '0;
                    init_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!empty) begin
                    case (head.action)
                        bfb_pkg::ACT_INSERT: begin
                            h1_next    = head.hash;
                            state_next = ST_MIX;
                        end
                        bfb_pkg::ACT_READ: begin
                            addr_next  = AW'(idx_wide);
                            oor_next   = (idx_wide >= FILTER_WORDS);
                            state_next = ST_RDREQ;
                        end
                        bfb_pkg::ACT_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MIX: begin
                // h1 was loaded on entry; start the mixer once.
                if (t_reg == 5'd0 && !mix_done) begin
                    mix_start = 1'b1;
                    t_next    = 5'd31;
                end
                if (mix_done) begin
                    h2_next    = mix_out;
                    acc_next   = h1_reg;
                    t_next     = 5'd0;
                    mod_start  = 1'b1;
                    mod_in     = h1_reg;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    addr_next  = AW'(word_wide);
                    bit_next   = mod_rem[5:0];
                    state_next = ST_SET;
                end
            end
            ST_SET: begin
                // Read was issued on the way in; rdata_reg holds the word now.
                mem_we = 1'b1;
                t_next = t_reg + 5'd1;
                if ((t_reg + 5'd1) == eff_k) begin
                    t_next     = 5'd0;
                    state_next = ST_IDLE;
                end else begin
                    acc_next   = acc_reg + h2_reg;
                    mod_start  = 1'b1;
                    mod_in     = acc_reg + h2_reg;
                    state_next = ST_MOD;
                end
            end
            ST_RDREQ: begin
                mem_re     = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = oor_reg ? 64'd0 : rdata_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The set step needs the old word: read it the cycle the position is known.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    assign rd_en   = mem_re || ((state_reg == ST_MOD) && mod_done);
    assign rd_addr = mem_re ? addr_reg : AW'(word_wide);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        acc_reg      <= acc_next;
        addr_reg     <= addr_next;
        bit_reg      <= bit_next;
        oor_reg      <= oor_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            t_reg         <= 5'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_addr_reg  <= clr_addr_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bloom_filter_builder_top.sv]
// Top level of the bloom filter builder: configuration registers and the
// front end, command queue and back end. Depends on bfb_pkg and all bfb_* modules.
`timescale 1ns / 1ps
`default_nettype none
// The builder hashes the bytes of each value with the 64-bit FNV-1a step
// (nonstandard offset basis) at one byte word per cycle, and on an
// end-of-value word inserts the value into a bloom filter of FILTER_WORDS
// 64-bit words using double hashing: h2 is the splitmix64 mix of h1, and bit
// (h1 + t*h2) mod filter_bits is set for t from 0 to num_hashes-1. Byte words
// are taken by the front end directly; insert, read and clear words go through
// a four-entry queue to the back end, so bytes of the next value keep flowing
// while an insert is being carried out. An insert runs h1 through the
// splitmix64 unit (one shared 32x32 multiplier, three partial products per
// 64-bit multiply), then each hash position through the modulo unit, which
// retires four bits per cycle, then a read and a write of the filter memory.
// A read word answers one read_word on the m_ channel, which has its own
// output register; a clear word sweeps the memory at one word per cycle. After
// reset the same sweep runs before any input word is accepted. num_hashes
// saturates to 1..16 and filter_bits to 8..64*FILTER_WORDS; a read of a word
// at or beyond FILTER_WORDS answers zero. The user must write configuration
// through cfg_we, cfg_index and cfg_wdata only while the block is idle; the
// block itself does not enforce this.
module bloom_filter_builder_top #(
    parameter int FILTER_WORDS = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [16:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_action,
    input  wire  [7:0]  s_data_byte,
    input  wire  [9:0]  s_word_index,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_read_word
);

    logic [4:0]    num_hashes_reg;
    logic [16:0]   filter_bits_reg;

    logic          push, pop, full, empty, init_done;
    bfb_pkg::cmd_t push_cmd, head;

    // Configuration registers, written with no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_hashes_reg  <= 5'd1;
            filter_bits_reg <= 17'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                bfb_pkg::CFG_NUM_HASHES: begin
                    num_hashes_reg <= cfg_wdata[4:0];
                end
                bfb_pkg::CFG_FILTER_BITS: begin
                    filter_bits_reg <= cfg_wdata;
                end
                default: begin
                    num_hashes_reg <= num_hashes_reg;
                end
            endcase
        end
    end

    bfb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (init_done),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_data_byte  (s_data_byte),
        .s_word_index (s_word_index),
        .push         (push),
        .push_cmd     (push_cmd),
        .queue_full   (full)
    );

    bfb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    bfb_back #(
        .FILTER_WORDS (FILTER_WORDS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .num_hashes  (num_hashes_reg),
        .filter_bits (filter_bits_reg),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .ready_init  (init_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_word (m_read_word)
    );

endmodule
`default_nettype wire
